// ===== hdl/dsc_pkg.sv =====
package dsc_pkg;

   // Field widths of the stream and register ports
   localparam int MODE_W      = 2;
   localparam int IDX_IN_W    = 4;
   localparam int COUNT_W     = 8;
   localparam int CFG_W       = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int FIN_CNT_W   = 5;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 8;

   // Work vector entries saturate at the top of their range
   localparam int WORK_W     = 13;
   localparam int WORK_SUM_W = WORK_W + 1;
   localparam logic [WORK_W-1:0] WORK_MAX = '1;

   // Item kinds carried on req_tuser
   localparam logic [MODE_W-1:0] MODE_LOAD_PROC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_AVAIL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RUN        = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PROC_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RES_COUNT  = 2'd1;
   localparam logic [CFG_W-1:0]       CFG_RESET      = 5'd16;

   // Controller to datapath commands
   typedef struct packed {
      logic load_proc;
      logic load_avail;
      logic start;
      logic clr_r;
      logic inc_r;
      logic clr_p;
      logic inc_p;
      logic copy_wr;
      logic give_wr;
      logic mark_fin;
      logic clr_progress;
      logic load_rsp;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic r_last;
      logic p_last;
      logic p_finished;
      logic no_fit;
      logic progress;
      logic all_done;
   } ctl_sts_type;

endpackage

// ===== hdl/dsc_ram.sv =====
module dsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Simple dual port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dsc_ctl.sv =====
module dsc_ctl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic [dsc_pkg::MODE_W-1:0]  req_mode,
   output logic                        req_tready,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   input  dsc_pkg::ctl_sts_type        sts,
   output dsc_pkg::ctl_cmd_type        cmd
);

   typedef enum logic [3:0] {
      IDLE,
      COPY_RD,
      COPY_WR,
      PROC_SEL,
      CHK_RD,
      CHK_CMP,
      GIVE_RD,
      GIVE_WR,
      ADV_P,
      ROUND_END,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               case (req_mode)
                  dsc_pkg::MODE_LOAD_PROC:  cmd.load_proc = 1'b1;
                  dsc_pkg::MODE_LOAD_AVAIL: cmd.load_avail = 1'b1;
                  dsc_pkg::MODE_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = COPY_RD;
                  end
                  default: ;
               endcase
            end
         end
         COPY_RD: state_in = COPY_WR;
         COPY_WR: begin
            cmd.copy_wr = 1'b1;
            if (sts.r_last) begin
               cmd.clr_r        = 1'b1;
               cmd.clr_p        = 1'b1;
               cmd.clr_progress = 1'b1;
               state_in         = PROC_SEL;
            end else begin
               cmd.inc_r = 1'b1;
               state_in  = COPY_RD;
            end
         end
         PROC_SEL: state_in = sts.p_finished ? ADV_P : CHK_RD;
         CHK_RD:   state_in = CHK_CMP;
         CHK_CMP: begin
            if (sts.no_fit) begin
               cmd.clr_r = 1'b1;
               state_in  = ADV_P;
            end else if (sts.r_last) begin
               cmd.clr_r = 1'b1;
               state_in  = GIVE_RD;
            end else begin
               cmd.inc_r = 1'b1;
               state_in  = CHK_RD;
            end
         end
         GIVE_RD: state_in = GIVE_WR;
         GIVE_WR: begin
            cmd.give_wr = 1'b1;
            if (sts.r_last) begin
               cmd.clr_r    = 1'b1;
               cmd.mark_fin = 1'b1;
               state_in     = ADV_P;
            end else begin
               cmd.inc_r = 1'b1;
               state_in  = GIVE_RD;
            end
         end
         ADV_P: begin
            if (sts.p_last) begin
               state_in = ROUND_END;
            end else begin
               cmd.inc_p = 1'b1;
               state_in  = PROC_SEL;
            end
         end
         ROUND_END: begin
            if (sts.progress && !sts.all_done) begin
               cmd.clr_p        = 1'b1;
               cmd.clr_progress = 1'b1;
               state_in         = PROC_SEL;
            end else begin
               state_in = FINISH;
            end
         end
         FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/dsc_dp.sv =====
module dsc_dp #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_RES   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dsc_pkg::ctl_cmd_type          cmd,
   output dsc_pkg::ctl_sts_type          sts,
   input  logic [dsc_pkg::CFG_W-1:0]     process_count,
   input  logic [dsc_pkg::CFG_W-1:0]     resource_count,
   input  logic [dsc_pkg::IDX_IN_W-1:0]  process_index,
   input  logic [dsc_pkg::IDX_IN_W-1:0]  resource_index,
   input  logic [dsc_pkg::COUNT_W-1:0]   alloc_count,
   input  logic [dsc_pkg::COUNT_W-1:0]   request_count,
   input  logic [dsc_pkg::COUNT_W-1:0]   avail_count,
   output logic                          safe,
   output logic [dsc_pkg::FIN_CNT_W-1:0] finished_count
);

   localparam int PIDX_W  = $clog2(MAX_PROCS);
   localparam int RIDX_W  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int DONE_W  = $clog2(MAX_PROCS + 1);
   localparam int RCNT_W  = $clog2(MAX_RES + 1);
   localparam int TDEPTH  = MAX_PROCS * MAX_RES;
   localparam int TADDR_W = $clog2(TDEPTH);
   localparam int TWIDTH  = 2 * dsc_pkg::COUNT_W;

   // Scan counters and run bounds
   logic [RIDX_W-1:0]    r_ff, last_r_ff;
   logic [PIDX_W-1:0]    p_ff, last_p_ff;
   logic [DONE_W-1:0]    np_ff, done_ff;
   logic [MAX_PROCS-1:0] fin_ff;
   logic                 progress_ff;
   logic                 safe_ff;
   logic [dsc_pkg::FIN_CNT_W-1:0] finished_ff;

   logic [DONE_W-1:0] np_clamp;
   logic [RCNT_W-1:0] nr_clamp;

   logic                  tbl_wr_en;
   logic [TADDR_W-1:0]    tbl_wr_addr, tbl_rd_addr;
   logic [TWIDTH-1:0]     tbl_rd;
   logic                  avail_wr_en;
   logic [dsc_pkg::COUNT_W-1:0] avail_rd;
   logic                  work_wr_en;
   logic [dsc_pkg::WORK_W-1:0]  work_rd, work_wr;
   logic [dsc_pkg::COUNT_W-1:0] held_rd, req_rd;
   logic [dsc_pkg::WORK_SUM_W-1:0] work_sum;
   logic                  p_ok, r_ok;

   // Clamp the register counts into the supported range
   always_comb begin
      if (process_count == '0) begin
         np_clamp = DONE_W'(1);
      end else if (32'(process_count) > 32'(MAX_PROCS)) begin
         np_clamp = DONE_W'(MAX_PROCS);
      end else begin
         np_clamp = DONE_W'(process_count);
      end
      if (resource_count == '0) begin
         nr_clamp = RCNT_W'(1);
      end else if (32'(resource_count) > 32'(MAX_RES)) begin
         nr_clamp = RCNT_W'(MAX_RES);
      end else begin
         nr_clamp = RCNT_W'(resource_count);
      end
   end

   // Load path: out-of-range indexes are dropped
   assign p_ok        = (32'(process_index) < 32'(MAX_PROCS));
   assign r_ok        = (32'(resource_index) < 32'(MAX_RES));
   assign tbl_wr_en   = cmd.load_proc && p_ok && r_ok;
   assign avail_wr_en = cmd.load_avail && r_ok;
   assign tbl_wr_addr = TADDR_W'(process_index) * TADDR_W'(MAX_RES)
                        + TADDR_W'(resource_index);
   assign tbl_rd_addr = TADDR_W'(p_ff) * TADDR_W'(MAX_RES) + TADDR_W'(r_ff);

   // Held and requested counts share one row: request high, held low
   dsc_ram #(
      .WIDTH (TWIDTH),
      .DEPTH (TDEPTH)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data ({request_count, alloc_count}),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd)
   );

   dsc_ram #(
      .WIDTH (dsc_pkg::COUNT_W),
      .DEPTH (MAX_RES)
   ) u_avail_ram (
      .clock   (clock),
      .wr_en   (avail_wr_en),
      .wr_addr (RIDX_W'(resource_index)),
      .wr_data (avail_count),
      .rd_addr (r_ff),
      .rd_data (avail_rd)
   );

   dsc_ram #(
      .WIDTH (dsc_pkg::WORK_W),
      .DEPTH (MAX_RES)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (work_wr_en),
      .wr_addr (r_ff),
      .wr_data (work_wr),
      .rd_addr (r_ff),
      .rd_data (work_rd)
   );

   // Work update: copy from available, or give back saturating
   assign held_rd    = tbl_rd[dsc_pkg::COUNT_W-1:0];
   assign req_rd     = tbl_rd[TWIDTH-1:dsc_pkg::COUNT_W];
   assign work_sum   = {1'b0, work_rd} + dsc_pkg::WORK_SUM_W'(held_rd);
   assign work_wr_en = cmd.copy_wr || cmd.give_wr;
   always_comb begin
      if (cmd.copy_wr) begin
         work_wr = dsc_pkg::WORK_W'(avail_rd);
      end else if (work_sum[dsc_pkg::WORK_W]) begin
         work_wr = dsc_pkg::WORK_MAX;
      end else begin
         work_wr = work_sum[dsc_pkg::WORK_W-1:0];
      end
   end

   // Counters, flags and bounds
   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff        <= '0;
         p_ff        <= '0;
         done_ff     <= '0;
         fin_ff      <= '0;
         progress_ff <= 1'b0;
      end else begin
         if (cmd.start || cmd.clr_r) begin
            r_ff <= '0;
         end else if (cmd.inc_r) begin
            r_ff <= r_ff + RIDX_W'(1);
         end
         if (cmd.start || cmd.clr_p) begin
            p_ff <= '0;
         end else if (cmd.inc_p) begin
            p_ff <= p_ff + PIDX_W'(1);
         end
         if (cmd.start) begin
            done_ff <= '0;
            fin_ff  <= '0;
         end else if (cmd.mark_fin) begin
            done_ff      <= done_ff + DONE_W'(1);
            fin_ff[p_ff] <= 1'b1;
         end
         if (cmd.start || cmd.clr_progress) begin
            progress_ff <= 1'b0;
         end else if (cmd.mark_fin) begin
            progress_ff <= 1'b1;
         end
      end
   end

   // Run bounds and result register
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         np_ff     <= np_clamp;
         last_p_ff <= PIDX_W'(np_clamp - DONE_W'(1));
         last_r_ff <= RIDX_W'(nr_clamp - RCNT_W'(1));
      end
      if (cmd.load_rsp) begin
         safe_ff     <= (done_ff == np_ff);
         finished_ff <= dsc_pkg::FIN_CNT_W'(done_ff);
      end
   end

   // Status to the controller
   assign sts.r_last     = (r_ff == last_r_ff);
   assign sts.p_last     = (p_ff == last_p_ff);
   assign sts.p_finished = fin_ff[p_ff];
   assign sts.no_fit     = (dsc_pkg::WORK_W'(req_rd) > work_rd);
   assign sts.progress   = progress_ff;
   assign sts.all_done   = (done_ff == np_ff);

   assign safe           = safe_ff;
   assign finished_count = finished_ff;

endmodule

// ===== hdl/deadlock_safety_check_core.sv =====
// Deadlock detection core. Load beats (kind 0: held and requested counts of
// one process/resource cell; kind 1: available count of one resource) take
// place while idle and give no result. A run beat (kind 2) copies the
// available counts into a work vector, then scans the processes round after
// round: an unfinished process whose requests all fit in the work vector
// gets its held counts added back (saturating at 8191) and is marked
// finished; rounds repeat while progress is made. One result beat follows
// with the safe flag and the number of finished processes. The run reads
// each table element in a read state and uses it in a write or compare
// state (COPY_RD/COPY_WR, CHK_RD/CHK_CMP, GIVE_RD/GIVE_WR): the copy, then
// per round and per unfinished process a compare of its requests (stopping
// at the first misfit) and a give-back, with a wait at the end while an
// earlier result still waits on the output. Input is not taken during a run;
// register writes are taken at any time.
module deadlock_safety_check_core #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_RES   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dsc_pkg::CFG_W-1:0]           csr_data,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // process_index[3:0], resource_index[7:4], alloc_count[15:8],
   // request_count[23:16], avail_count[31:24]
   input  logic [dsc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // mode[1:0]
   input  logic [dsc_pkg::MODE_W-1:0]          req_tuser,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // safe[0], finished_count[5:1], zero[7:6]
   output logic [dsc_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic [dsc_pkg::CFG_W-1:0]     proc_count_ff, res_count_ff;
   dsc_pkg::ctl_cmd_type          ctl_cmd;
   dsc_pkg::ctl_sts_type          ctl_sts;
   logic                          safe;
   logic [dsc_pkg::FIN_CNT_W-1:0] finished_count;

   // Configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         proc_count_ff <= dsc_pkg::CFG_RESET;
         res_count_ff  <= dsc_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dsc_pkg::CSR_PROC_COUNT: proc_count_ff <= csr_data;
            dsc_pkg::CSR_RES_COUNT:  res_count_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   dsc_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .sts        (ctl_sts),
      .cmd        (ctl_cmd)
   );

   dsc_dp #(
      .MAX_PROCS (MAX_PROCS),
      .MAX_RES   (MAX_RES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctl_cmd),
      .sts            (ctl_sts),
      .process_count  (proc_count_ff),
      .resource_count (res_count_ff),
      .process_index  (req_tdata[3:0]),
      .resource_index (req_tdata[7:4]),
      .alloc_count    (req_tdata[15:8]),
      .request_count  (req_tdata[23:16]),
      .avail_count    (req_tdata[31:24]),
      .safe           (safe),
      .finished_count (finished_count)
   );

   assign rsp_tdata = {2'b00, finished_count, safe};

`ifndef SYNTHESIS
   // a run start closes the input until the result is built
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.start |=> !req_tready)
      else $error("input open right after run start");

   // a process is granted at most once per run
   a_single_grant: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.mark_fin |-> !ctl_sts.p_finished)
      else $error("process granted twice");

   // safe flag agrees with the finish count when loaded
   a_safe_match: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.load_rsp |=> (rsp_tdata[0] == ctl_sts.all_done) && rsp_tvalid)
      else $error("safe flag does not match finish count");
`endif

endmodule

// ===== tb/sv/deadlock_safety_check_core_tb.sv =====
`timescale 1ns / 1ps

module deadlock_safety_check_core_tb;

   localparam int MAX_PROCS       = 16;
   localparam int MAX_RES         = 16;
   localparam int STALL_LIMIT     = 100000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int END_DRAIN       = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASES          = 12;

   // beat kind not used by the block, and a register index it does not decode
   localparam logic [dsc_pkg::MODE_W-1:0]      MODE_UNUSED = 2'd3;
   localparam logic [dsc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED  = 2'd3;

   typedef struct packed {
      logic                          safe;
      logic [dsc_pkg::FIN_CNT_W-1:0] finished;
   } verdict_type;

   // Mirror of the detection core: tables, registers and pending verdicts
   class deadlock_predictor_type;
      logic [dsc_pkg::COUNT_W-1:0] held_cnt [MAX_PROCS][MAX_RES];
      logic [dsc_pkg::COUNT_W-1:0] want_cnt [MAX_PROCS][MAX_RES];
      logic [dsc_pkg::COUNT_W-1:0] free_cnt [MAX_RES];
      logic [dsc_pkg::CFG_W-1:0]   proc_reg = dsc_pkg::CFG_RESET;
      logic [dsc_pkg::CFG_W-1:0]   res_reg  = dsc_pkg::CFG_RESET;
      verdict_type                 expected_verdicts [$];
      int                          mismatches = 0;
      int                          verdicts_checked = 0;
      int                          safe_seen = 0;
      int                          load_beats = 0;

      function void write_reg(logic [dsc_pkg::CSR_INDEX_W-1:0] idx,
                              logic [dsc_pkg::CFG_W-1:0] val);
         if (idx == dsc_pkg::CSR_PROC_COUNT) proc_reg = val;
         else if (idx == dsc_pkg::CSR_RES_COUNT) res_reg = val;
      endfunction

      function void note_beat(logic [dsc_pkg::MODE_W-1:0] mode,
                              logic [dsc_pkg::REQ_DATA_W-1:0] data);
         logic [dsc_pkg::IDX_IN_W-1:0]   pi;
         logic [dsc_pkg::IDX_IN_W-1:0]   ri;
         logic [dsc_pkg::WORK_W-1:0]     work [MAX_RES];
         logic [dsc_pkg::WORK_SUM_W-1:0] sum;
         logic [MAX_PROCS-1:0]           fin;
         int np, nr, done, p, r;
         bit progress, fits;
         verdict_type v;
         pi = data[3:0];
         ri = data[7:4];
         case (mode)
            dsc_pkg::MODE_LOAD_PROC: begin
               held_cnt[pi][ri] = data[15:8];
               want_cnt[pi][ri] = data[23:16];
               load_beats++;
            end
            dsc_pkg::MODE_LOAD_AVAIL: begin
               free_cnt[ri] = data[31:24];
               load_beats++;
            end
            dsc_pkg::MODE_RUN: begin
               np = (proc_reg == 0) ? 1 : (proc_reg > MAX_PROCS) ? MAX_PROCS : proc_reg;
               nr = (res_reg == 0) ? 1 : (res_reg > MAX_RES) ? MAX_RES : res_reg;
               for (r = 0; r < MAX_RES; r++)
                  work[r] = (r < nr) ? dsc_pkg::WORK_W'(free_cnt[r]) : '0;
               fin = '0;
               done = 0;
               progress = 1;
               // scan rounds until nobody new can finish
               while (progress && done < np) begin
                  progress = 0;
                  for (p = 0; p < np; p++) begin
                     if (!fin[p]) begin
                        fits = 1;
                        for (r = 0; r < nr; r++)
                           if (dsc_pkg::WORK_W'(want_cnt[p][r]) > work[r]) fits = 0;
                        if (fits) begin
                           // grant, run to completion, give back holdings
                           for (r = 0; r < nr; r++) begin
                              sum = work[r] + held_cnt[p][r];
                              work[r] = (sum > dsc_pkg::WORK_MAX) ?
                                        dsc_pkg::WORK_MAX : sum[dsc_pkg::WORK_W-1:0];
                           end
                           fin[p] = 1'b1;
                           done++;
                           progress = 1;
                        end
                     end
                  end
               end
               v.safe = (done == np);
               v.finished = done[dsc_pkg::FIN_CNT_W-1:0];
               expected_verdicts.push_back(v);
            end
            default: ;
         endcase
      endfunction

      function void check_verdict(logic [dsc_pkg::RSP_DATA_W-1:0] data);
         verdict_type want;
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, data);
            mismatches++;
            return;
         end
         want = expected_verdicts.pop_front();
         verdicts_checked++;
         if (want.safe) safe_seen++;
         if (data[0] !== want.safe) begin
            $display("%0t: safe mismatch, expected %0b actual %0b", $time, want.safe, data[0]);
            mismatches++;
         end
         if (data[5:1] !== want.finished) begin
            $display("%0t: finished_count mismatch, expected %0d actual %0d",
                     $time, want.finished, data[5:1]);
            mismatches++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [dsc_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [dsc_pkg::CFG_W-1:0]       csr_data   = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dsc_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [dsc_pkg::MODE_W-1:0]      req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dsc_pkg::RSP_DATA_W-1:0]  rsp_tdata;

   bit quiet_tail       = 0;
   bit hold_off_pending = 0;
   int settings_used    = 0;

   deadlock_predictor_type model = new();

   deadlock_safety_check_core #(
      .MAX_PROCS(MAX_PROCS),
      .MAX_RES  (MAX_RES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // mostly small counts, now and then a full-range one
   function automatic logic [dsc_pkg::COUNT_W-1:0] pick_count();
      if ($urandom_range(0, 3) == 0) return dsc_pkg::COUNT_W'($urandom_range(0, 255));
      return dsc_pkg::COUNT_W'($urandom_range(0, 6));
   endfunction

   // one request beat, with an optional idle burst ahead of it
   task automatic send_beat(input logic [dsc_pkg::MODE_W-1:0] mode,
                            input logic [dsc_pkg::REQ_DATA_W-1:0] data);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      model.note_beat(mode, data);
   endtask

   task automatic load_cell(input int p, input int r, input int held, input int want);
      send_beat(dsc_pkg::MODE_LOAD_PROC,
                {dsc_pkg::COUNT_W'($urandom_range(0, 255)), dsc_pkg::COUNT_W'(want),
                 dsc_pkg::COUNT_W'(held), dsc_pkg::IDX_IN_W'(r), dsc_pkg::IDX_IN_W'(p)});
   endtask

   task automatic load_free(input int r, input int n);
      send_beat(dsc_pkg::MODE_LOAD_AVAIL,
                {dsc_pkg::COUNT_W'(n), dsc_pkg::COUNT_W'($urandom_range(0, 255)),
                 dsc_pkg::COUNT_W'($urandom_range(0, 255)), dsc_pkg::IDX_IN_W'(r),
                 dsc_pkg::IDX_IN_W'($urandom_range(0, 15))});
   endtask

   task automatic start_check();
      send_beat(dsc_pkg::MODE_RUN, dsc_pkg::REQ_DATA_W'($urandom()));
   endtask

   task automatic write_reg(input logic [dsc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dsc_pkg::CFG_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      model.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drop valid, let every verdict come back, then give trailing loads time
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (model.expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_counts(input int np, input int nr);
      settle();
      write_reg(dsc_pkg::CSR_PROC_COUNT, dsc_pkg::CFG_W'(np));
      write_reg(dsc_pkg::CSR_RES_COUNT, dsc_pkg::CFG_W'(nr));
      settings_used++;
   endtask

   // load/run sequences aimed at the active region, with some noise mixed in
   task automatic random_phase(input int items, input int ap, input int ar);
      int sel;
      repeat (items) begin
         sel = $urandom_range(0, 99);
         if (sel < 12)
            start_check();
         else if (sel < 62)
            load_cell($urandom_range(0, ap - 1), $urandom_range(0, ar - 1),
                      ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) : $urandom_range(0, 6),
                      int'(pick_count()));
         else if (sel < 80)
            load_free($urandom_range(0, ar - 1), int'(pick_count()));
         else if (sel < 92)
            load_cell($urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 255), $urandom_range(0, 255));
         else if (sel < 96)
            load_free($urandom_range(0, 15), $urandom_range(0, 255));
         else
            send_beat(MODE_UNUSED, dsc_pkg::REQ_DATA_W'($urandom()));
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) model.check_verdict(rsp_tdata);
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin : rsp_side
      @(negedge clock iff !reset);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 0;
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles without any accepted beat
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("deadlock_safety_check_core_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      int p, r, phase, np, nr, ap, ar;
      bit big;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every table entry written once so no check reads an unwritten cell
      for (p = 0; p < MAX_PROCS; p++)
         for (r = 0; r < MAX_RES; r++)
            load_cell(p, r, $urandom_range(0, 255), $urandom_range(0, 255));
      for (r = 0; r < MAX_RES; r++) load_free(r, $urandom_range(0, 255));

      // full-size check at reset counts
      start_check();

      // three processes on one resource that finish over several rounds
      set_counts(3, 1);
      load_free(0, 1);
      load_cell(0, 0, 5, 5);
      load_cell(1, 0, 4, 3);
      load_cell(2, 0, 2, 1);
      start_check();

      // extreme counts: nothing free means deadlock, all free means safe
      load_cell(0, 0, 255, 255);
      load_free(0, 0);
      start_check();
      load_free(0, 255);
      start_check();
      send_beat(MODE_UNUSED, '1);

      // zero counts behave as one, oversized counts as the maximum
      set_counts(0, 0);
      start_check();
      set_counts(31, 31);
      start_check();
      settle();
      write_reg(CSR_UNUSED, dsc_pkg::CFG_W'($urandom_range(0, 31)));
      start_check();

      // random phases, mostly small sizes, two at full size
      for (phase = 0; phase < PHASES; phase++) begin
         big = (phase == 3 || phase == 9);
         if (big) begin
            np = $urandom_range(16, 31);
            nr = $urandom_range(16, 31);
         end else begin
            np = $urandom_range(0, 5);
            nr = $urandom_range(0, 4);
         end
         set_counts(np, nr);
         ap = (np == 0) ? 1 : (np > MAX_PROCS) ? MAX_PROCS : np;
         ar = (nr == 0) ? 1 : (nr > MAX_RES) ? MAX_RES : nr;
         if (phase == 5) hold_off_pending = 1;
         if (phase == PHASES - 1) quiet_tail = 1;
         random_phase(big ? 40 : 90, ap, ar);
      end

      settle();
      repeat (END_DRAIN) @(posedge clock);
      model.mismatches += model.expected_verdicts.size();
      $display("ran %0d load beats and %0d checks (%0d safe, %0d with deadlock)",
               model.load_beats, model.verdicts_checked, model.safe_seen,
               model.verdicts_checked - model.safe_seen);
      $display("over %0d register settings, including zero and oversized counts",
               settings_used + 1);
      if (model.mismatches == 0)
         $display("deadlock_safety_check_core_tb OK");
      else
         $display("deadlock_safety_check_core_tb NOT OK");
      $finish;
   end

endmodule
